@@ design/drc_pkg.sv @@
// Package for the drip-rate controller: widths, constants, configuration
// and result structs, state and code enums shared by all modules.
// No dependencies.
package drc_pkg;

  // Width of the millisecond time base; differences wrap modulo 2**TIME_BITS.
  localparam int unsigned TIME_BITS    = 32;
  // Proportional gain is error / GAIN_DIVISOR, truncated toward zero.
  localparam int unsigned GAIN_DIVISOR = 5;

  // Serial divider width: covers pot * 100 (up to 102300) and 60000.
  localparam int unsigned DIV_BITS = 17;
  localparam int unsigned CNT_BITS = $clog2(DIV_BITS + 1);

  localparam int unsigned DROP_NUMERATOR = 60000;
  localparam int unsigned POT_FULL_SCALE = 1023;
  localparam logic [8:0]  RATE_MAX       = 9'd511;
  localparam logic [7:0]  SERVO_RESET    = 8'd90;

  // Configuration reset values.
  localparam logic [15:0] LOCKOUT_RESET   = 16'd150;
  localparam logic [15:0] PERIOD_RESET    = 16'd1000;
  localparam logic [7:0]  DEADBAND_RESET  = 8'd5;
  localparam logic [7:0]  SERVO_MIN_RESET = 8'd20;
  localparam logic [7:0]  SERVO_MAX_RESET = 8'd160;
  localparam logic [7:0]  MARGIN_RESET    = 8'd15;
  localparam logic [15:0] OCCLUSION_RESET = 16'd12000;
  localparam logic [15:0] REPEAT_RESET    = 16'd500;

  typedef logic [TIME_BITS-1:0] ms_t;
  typedef logic [DIV_BITS-1:0]  div_word_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_LOCKOUT   = 3'd0,
    CFG_PERIOD    = 3'd1,
    CFG_DEADBAND  = 3'd2,
    CFG_SERVO_MIN = 3'd3,
    CFG_SERVO_MAX = 3'd4,
    CFG_MARGIN    = 3'd5,
    CFG_OCCLUSION = 3'd6,
    CFG_REPEAT    = 3'd7
  } cfg_idx_e;

  // Alarm action codes.
  typedef enum logic [1:0] {
    ALARM_NONE      = 2'd0,
    ALARM_OVERFLOW  = 2'd1,
    ALARM_OCCLUSION = 2'd2,
    ALARM_SILENCE   = 2'd3
  } alarm_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_TGT_DIV,
    S_CTRL_CHK,
    S_GAIN_DIV,
    S_REPEAT_CHK,
    S_OCCL_CHK,
    S_DROP_CHK,
    S_RATE_DIV,
    S_FINISH
  } seq_state_e;

  typedef struct packed {
    logic [15:0] lockout_ms;
    logic [15:0] control_period_ms;
    logic [7:0]  deadband;
    logic [7:0]  servo_min;
    logic [7:0]  servo_max;
    logic [7:0]  overflow_margin;
    logic [15:0] occlusion_ms;
    logic [15:0] alarm_repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic      start;
    div_word_t dividend;
    div_word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic      done;
    div_word_t quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [6:0] target_rate;
    logic [8:0] drop_rate;
    logic [7:0] servo_position;
    alarm_e     alarm_action;
  } result_t;

endpackage

@@ design/drc_serial_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on drc_pkg.
module drc_serial_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  drc_pkg::div_req_t  req_i,
  output drc_pkg::div_rsp_t  rsp_o
);
  import drc_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  div_word_t           rem_q, rem_d;
  div_word_t           quo_q, quo_d;
  div_word_t           dsr_q, dsr_d;

  logic [DIV_BITS:0]   trial;
  logic [DIV_BITS:0]   diff;
  logic                fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[DIV_BITS-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = (trial >= {1'b0, dsr_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(DIV_BITS);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      quo_d = {quo_q[DIV_BITS-2:0], fits};
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  // After the last step the shift register holds the quotient.
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ design/drc_core.sv @@
// Controller sequencer: time base, target, servo and alarm state, and the
// step-by-step control pass. Depends on drc_pkg and drc_serial_div.
module drc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drc_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [9:0]        pot_value_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output drc_pkg::result_t  res_o
);
  import drc_pkg::*;

  seq_state_e state_q, state_d;
  ms_t        now_q, now_d;
  ms_t        last_drop_q, last_drop_d;
  ms_t        last_ctrl_q, last_ctrl_d;
  ms_t        last_alarm_q, last_alarm_d;
  logic [8:0] rate_q, rate_d;
  logic [7:0] servo_q, servo_d;
  logic [6:0] target_q, target_d;
  alarm_e     alarm_q, alarm_d;
  logic       repeat_ok_q, repeat_ok_d;
  logic       err_neg_q, err_neg_d;

  div_req_t   div_req;
  div_rsp_t   div_rsp;

  ms_t               ref_ms;
  logic [15:0]       lim_ms;
  ms_t               elapsed;
  logic              late;
  div_word_t         drop_divisor;
  logic [10:0]       err;
  logic [10:0]       err_mag;
  logic [9:0]        ovf_limit;
  logic signed [10:0] pos;
  logic signed [10:0] lo_s;
  logic signed [10:0] hi_s;
  logic signed [10:0] clamped;
  logic [10:0]       step;

  drc_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Shared elapsed-time compare; the state picks the time stamp and limit.
  always_comb begin
    unique case (state_q)
      S_CTRL_CHK: begin
        ref_ms = last_ctrl_q;
        lim_ms = cfg_i.control_period_ms;
      end
      S_REPEAT_CHK: begin
        ref_ms = last_alarm_q;
        lim_ms = cfg_i.alarm_repeat_ms;
      end
      S_OCCL_CHK: begin
        ref_ms = last_drop_q;
        lim_ms = cfg_i.occlusion_ms;
      end
      default: begin
        ref_ms = last_drop_q;
        lim_ms = cfg_i.lockout_ms;
      end
    endcase
    elapsed = now_q - ref_ms;
    late    = (elapsed > ms_t'(lim_ms));
    // Intervals too long for the divider give a zero rate either way.
    drop_divisor = (elapsed > ms_t'({DIV_BITS{1'b1}})) ? '1 : DIV_BITS'(elapsed);
  end

  // Error, overflow limit and clamped servo position.
  always_comb begin
    err       = {4'b0, target_q} - {2'b0, rate_q};
    err_mag   = err[10] ? (11'd0 - err) : err;
    ovf_limit = {3'b0, target_q} + {2'b0, cfg_i.overflow_margin};
    step      = div_rsp.quotient[10:0];
    pos       = err_neg_q ? $signed({3'b0, servo_q} - step)
                          : $signed({3'b0, servo_q} + step);
    lo_s      = $signed({3'b0, cfg_i.servo_min});
    hi_s      = $signed({3'b0, cfg_i.servo_max});
    if (pos < lo_s) begin
      clamped = lo_s;
    end else if (pos > hi_s) begin
      clamped = hi_s;
    end else begin
      clamped = pos;
    end
  end

  // Next state and datapath updates.
  always_comb begin
    state_d      = state_q;
    now_d        = now_q;
    last_drop_d  = last_drop_q;
    last_ctrl_d  = last_ctrl_q;
    last_alarm_d = last_alarm_q;
    rate_d       = rate_q;
    servo_d      = servo_q;
    target_d     = target_q;
    alarm_d      = alarm_q;
    repeat_ok_d  = repeat_ok_q;
    err_neg_d    = err_neg_q;
    div_req      = '0;
    in_stall_o   = 1'b1;
    res_valid_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (!kind_i) begin
            // Tick: advance time and start target = pot * 100 / 1023.
            now_d            = now_q + ms_t'(1);
            div_req.start    = 1'b1;
            div_req.dividend = DIV_BITS'({pot_value_i, 6'b0})
                             + DIV_BITS'({pot_value_i, 5'b0})
                             + DIV_BITS'({pot_value_i, 2'b0});
            div_req.divisor  = DIV_BITS'(POT_FULL_SCALE);
            state_d          = S_TGT_DIV;
          end else begin
            state_d = S_DROP_CHK;
          end
        end
      end
      S_TGT_DIV: begin
        if (div_rsp.done) begin
          target_d = div_rsp.quotient[6:0];
          state_d  = S_CTRL_CHK;
        end
      end
      S_CTRL_CHK: begin
        state_d = S_REPEAT_CHK;
        if (late) begin
          last_ctrl_d = now_q;
          if (err_mag > {3'b0, cfg_i.deadband}) begin
            err_neg_d        = err[10];
            div_req.start    = 1'b1;
            div_req.dividend = DIV_BITS'(err_mag);
            div_req.divisor  = DIV_BITS'(GAIN_DIVISOR);
            state_d          = S_GAIN_DIV;
          end
        end
      end
      S_GAIN_DIV: begin
        if (div_rsp.done) begin
          servo_d = clamped[7:0];
          state_d = S_REPEAT_CHK;
        end
      end
      S_REPEAT_CHK: begin
        repeat_ok_d = late;
        if ((target_q != '0) && ({1'b0, rate_q} > ovf_limit)) begin
          // Overflow wins over occlusion.
          if (late) begin
            last_alarm_d = now_q;
            alarm_d      = ALARM_OVERFLOW;
          end else begin
            alarm_d = ALARM_NONE;
          end
          state_d = S_FINISH;
        end else if (target_q == '0) begin
          alarm_d = ALARM_SILENCE;
          state_d = S_FINISH;
        end else begin
          state_d = S_OCCL_CHK;
        end
      end
      S_OCCL_CHK: begin
        if (late) begin
          if (repeat_ok_q) begin
            last_alarm_d = now_q;
            rate_d       = '0;
            alarm_d      = ALARM_OCCLUSION;
          end else begin
            alarm_d = ALARM_NONE;
          end
        end else begin
          alarm_d = ALARM_SILENCE;
        end
        state_d = S_FINISH;
      end
      S_DROP_CHK: begin
        // Drop items never raise an alarm; lockout filters bounces.
        alarm_d = ALARM_NONE;
        if (late) begin
          last_drop_d      = now_q;
          div_req.start    = 1'b1;
          div_req.dividend = DIV_BITS'(DROP_NUMERATOR);
          div_req.divisor  = drop_divisor;
          state_d          = S_RATE_DIV;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_RATE_DIV: begin
        if (div_rsp.done) begin
          rate_d  = (div_rsp.quotient > DIV_BITS'(RATE_MAX)) ? RATE_MAX
                                                             : div_rsp.quotient[8:0];
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      now_q        <= '0;
      last_drop_q  <= '0;
      last_ctrl_q  <= '0;
      last_alarm_q <= '0;
      rate_q       <= '0;
      servo_q      <= SERVO_RESET;
      target_q     <= '0;
      alarm_q      <= ALARM_NONE;
    end else begin
      state_q      <= state_d;
      now_q        <= now_d;
      last_drop_q  <= last_drop_d;
      last_ctrl_q  <= last_ctrl_d;
      last_alarm_q <= last_alarm_d;
      rate_q       <= rate_d;
      servo_q      <= servo_d;
      target_q     <= target_d;
      alarm_q      <= alarm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    repeat_ok_q <= repeat_ok_d;
    err_neg_q   <= err_neg_d;
  end

  assign res_o.target_rate    = target_q;
  assign res_o.drop_rate      = rate_q;
  assign res_o.servo_position = servo_q;
  assign res_o.alarm_action   = alarm_q;

endmodule

@@ design/drip_rate_controller.sv @@
// Drip-rate controller top level. A tick item makes one or two passes of the
// bit-serial divider; a drop item makes none or one. One item is in work at a
// time; the result register lets the next item in while a result waits. Reset
// restores all configuration registers to their defaults, time stamps to zero
// and the servo to 90 degrees.
// Depends on drc_pkg and drc_core.
module drip_rate_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [9:0]  pot_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  target_rate_o,
  output logic [8:0]  drop_rate_o,
  output logic [7:0]  servo_position_o,
  output logic [1:0]  alarm_action_o
);
  import drc_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  result_t res;
  logic    res_valid;
  logic    res_ready;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOCKOUT:   cfg_d.lockout_ms        = cfg_data_i;
        CFG_PERIOD:    cfg_d.control_period_ms = cfg_data_i;
        CFG_DEADBAND:  cfg_d.deadband          = cfg_data_i[7:0];
        CFG_SERVO_MIN: cfg_d.servo_min         = cfg_data_i[7:0];
        CFG_SERVO_MAX: cfg_d.servo_max         = cfg_data_i[7:0];
        CFG_MARGIN:    cfg_d.overflow_margin   = cfg_data_i[7:0];
        CFG_OCCLUSION: cfg_d.occlusion_ms      = cfg_data_i;
        CFG_REPEAT:    cfg_d.alarm_repeat_ms   = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lockout_ms        <= LOCKOUT_RESET;
      cfg_q.control_period_ms <= PERIOD_RESET;
      cfg_q.deadband          <= DEADBAND_RESET;
      cfg_q.servo_min         <= SERVO_MIN_RESET;
      cfg_q.servo_max         <= SERVO_MAX_RESET;
      cfg_q.overflow_margin   <= MARGIN_RESET;
      cfg_q.occlusion_ms      <= OCCLUSION_RESET;
      cfg_q.alarm_repeat_ms   <= REPEAT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  drc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .pot_value_i (pot_value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: takes a new result when empty or being drained.
  always_comb begin
    res_ready   = !out_valid_q || !out_stall_i;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (res_valid && res_ready) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign target_rate_o    = out_q.target_rate;
  assign drop_rate_o      = out_q.drop_rate;
  assign servo_position_o = out_q.servo_position;
  assign alarm_action_o   = out_q.alarm_action;

endmodule
